@@ rtl/kmce_pkg.sv @@
// kmce_pkg: shared types and constants for the keypad matrix change-event block.
// No dependencies; imported by every module of the block.
package kmce_pkg;

	localparam int COL_BITS     = 8;
	localparam int KEY_W        = 7;
	localparam int KEY_COL_W    = 4;
	localparam int COLS_W       = 5;
	localparam int ROWS_W       = 4;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 5;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [COLS_W-1:0] COLS_RESET = 5'd16;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 4'd8;
	localparam logic [ROWS_W-1:0] ROWS_MAX   = 4'd8;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_COLUMN = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS_IN_USE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE    = 1'd1;

	localparam int SWITCH_BIT = 0;

	// One word of work for the event generator
	typedef struct packed {
		logic                 is_switch;
		logic                 level;
		logic [KEY_COL_W-1:0] col;
		logic [COL_BITS-1:0]  on;
		logic [COL_BITS-1:0]  off;
	} job_t;

endpackage

@@ rtl/kmce_queue.sv @@
// kmce_queue: small register FIFO carrying jobs from front to back.
// Depends on kmce_pkg (job_t).
module kmce_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kmce_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output kmce_pkg::job_t head
);
	import kmce_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t           mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/kmce_front.sv @@
// kmce_front: accepts report bytes, holds column store, switch level and config,
// turns each byte into a job of changed bits. Depends on kmce_pkg.
module kmce_front #(
	parameter int MAX_COLUMNS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [kmce_pkg::COL_BITS-1:0]         s_axis_tdata,
	input  logic                                  s_axis_tuser,
	input  logic                                  cfg_we,
	input  logic [kmce_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [kmce_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  job_push,
	output kmce_pkg::job_t                        job,
	input  logic                                  job_full
);
	import kmce_pkg::*;

	localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int PW = $clog2(MAX_COLUMNS + 1);

	logic [COL_BITS-1:0] prev_q [MAX_COLUMNS];
	logic                switch_q;
	logic [PW-1:0]       pos_q;
	logic [COLS_W-1:0]   columns_q;
	logic [ROWS_W-1:0]   rows_q;

	logic                accept;
	logic [5:0]          cols_req;
	logic [5:0]          cols_eff;
	logic                in_range;
	logic [ROWS_W-1:0]   rows_eff;
	logic [COL_BITS-1:0] mask;
	logic [COL_BITS-1:0] old_byte;
	logic [COL_BITS-1:0] on_bits;
	logic [COL_BITS-1:0] off_bits;
	logic                level;
	logic [31:0]         pos_w;

	assign s_axis_tready = !job_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign cols_req = {1'b0, columns_q};
	assign cols_eff = (cols_req > 6'(MAX_COLUMNS)) ? 6'(MAX_COLUMNS) : cols_req;
	assign in_range = 6'(pos_q) < cols_eff;
	assign rows_eff = (rows_q > ROWS_MAX) ? ROWS_MAX : rows_q;
	assign mask     = ~(8'hFF << rows_eff);
	assign old_byte = prev_q[pos_q[IW-1:0]];
	assign on_bits  = s_axis_tdata & ~old_byte & mask;
	assign off_bits = ~s_axis_tdata & old_byte & mask;
	assign level    = s_axis_tdata[SWITCH_BIT];
	assign pos_w    = 32'(pos_q);

	always_comb begin
		job.is_switch = (s_axis_tuser == KIND_STATUS);
		job.level     = level;
		job.col       = pos_w[KEY_COL_W-1:0];
		job.on        = on_bits;
		job.off       = off_bits;
		if (s_axis_tuser == KIND_STATUS) begin
			job_push = accept && (level != switch_q);
		end else begin
			job_push = accept && in_range && ((on_bits | off_bits) != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_COLUMNS; i++) begin
				prev_q[i] <= '0;
			end
			switch_q  <= 1'b0;
			pos_q     <= '0;
			columns_q <= COLS_RESET;
			rows_q    <= ROWS_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COLUMNS_IN_USE: columns_q <= cfg_data;
					REG_ROWS_IN_USE:    rows_q    <= cfg_data[ROWS_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (s_axis_tuser == KIND_STATUS) begin
					pos_q    <= '0;
					switch_q <= level;
				end else if (in_range) begin
					prev_q[pos_q[IW-1:0]] <= s_axis_tdata;
					pos_q                 <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/kmce_back.sv @@
// kmce_back: drains jobs into single events, presses then releases, low row first.
// Registered output word. Depends on kmce_pkg.
module kmce_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_empty,
	input  kmce_pkg::job_t                job,
	output logic                          job_pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [kmce_pkg::COL_BITS-1:0] m_axis_tdata,
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);
	import kmce_pkg::*;

	job_t                busy_job_q;
	logic                busy_q;
	logic                m_valid_q;
	logic [KEY_W-1:0]    key_q;
	logic                pressed_q;
	logic                switch_q;
	logic                last_q;

	job_t                cur;
	logic                cur_valid;
	logic                advance;
	logic [COL_BITS-1:0] scan;
	logic                scan_on;
	logic [2:0]          row;
	logic [COL_BITS-1:0] on_next;
	logic [COL_BITS-1:0] off_next;
	logic                done;

	assign cur       = busy_q ? busy_job_q : job;
	assign cur_valid = busy_q || !job_empty;
	assign advance   = cur_valid && (!m_valid_q || m_axis_tready);
	assign job_pop   = advance && !busy_q;

	assign scan_on = (cur.on != '0);
	assign scan    = scan_on ? cur.on : cur.off;

	always_comb begin
		row = '0;
		for (int i = COL_BITS - 1; i >= 0; i--) begin
			if (scan[i]) begin
				row = 3'(i);
			end
		end
	end

	assign on_next  = scan_on ? (cur.on & (cur.on - 1'b1)) : cur.on;
	assign off_next = scan_on ? cur.off : (cur.off & (cur.off - 1'b1));
	assign done     = cur.is_switch || ((on_next | off_next) == '0);

	always_ff @(posedge clk) begin
		if (advance) begin
			busy_job_q <= '{is_switch: cur.is_switch, level: cur.level, col: cur.col,
				on: on_next, off: off_next};
			key_q      <= cur.is_switch ? '0 : {cur.col, row};
			pressed_q  <= cur.is_switch ? cur.level : scan_on;
			switch_q   <= cur.is_switch;
			last_q     <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				busy_q    <= !done;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {pressed_q, key_q};
	assign m_axis_tuser  = switch_q;
	assign m_axis_tlast  = last_q;

endmodule

@@ rtl/key_matrix_change_events.sv @@
// key_matrix_change_events: keypad report bytes in, press/release events out.
// Depends on kmce_pkg, kmce_front, kmce_queue, kmce_back.
//
// channel | dir | tdata                           | tuser          | tlast
// s_axis  | in  | byte_value[7:0]                 | kind           | -
// m_axis  | out | key_index[6:0], pressed[7]      | program_switch | last_event
// cfg     | in  | cfg_we / cfg_index / cfg_data (columns_in_use=0, rows_in_use=1)
//
// One input word per cycle while the job queue has room; the back-end scanner sends
// the events of a byte one per cycle while m_axis_tready does not stall the output.
// Column store, switch level and column position clear at reset, no sweep.
// Input stalls only when the 4-entry job queue is full; output is registered.
module key_matrix_change_events #(
	parameter int MAX_COLUMNS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [kmce_pkg::COL_BITS-1:0]         s_axis_tdata,  // byte_value
	input  logic                                  s_axis_tuser,  // kind
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [kmce_pkg::COL_BITS-1:0]         m_axis_tdata,  // key_index, pressed
	output logic                                  m_axis_tuser,  // program_switch
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_we,
	input  logic [kmce_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [kmce_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import kmce_pkg::*;

	logic job_push;
	job_t push_job;
	logic job_full;
	logic job_pop;
	logic job_empty;
	job_t head_job;

	kmce_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.job_push      (job_push),
		.job           (push_job),
		.job_full      (job_full)
	);

	kmce_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (job_full),
		.pop      (job_pop),
		.empty    (job_empty),
		.head     (head_job)
	);

	kmce_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_empty     (job_empty),
		.job           (head_job),
		.job_pop       (job_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ tb/testbench.sv @@
// Testbench for key_matrix_change_events: keypad report words in, press/release events out.
// Predicts events with a scoreboard class; needs kmce_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import kmce_pkg::*;

	localparam int MAX_COLS = 16;

	typedef struct packed {
		logic [KEY_W-1:0] key_index;
		logic             program_switch;
		logic             pressed;
		logic             last_event;
	} key_event_t;

	class keypad_event_predictor;
		int unsigned  columns_in_use;
		int unsigned  rows_in_use;
		logic [7:0]   column_store [MAX_COLS];
		logic         switch_level;
		int           column_pos;
		key_event_t   expected_events [$];
		int           errors;

		function new();
			columns_in_use = COLS_RESET;
			rows_in_use = ROWS_RESET;
			foreach (column_store[i]) column_store[i] = 8'h00;
			switch_level = 1'b0;
			column_pos = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_COLUMNS_IN_USE)
				columns_in_use = value;
			else if (idx == REG_ROWS_IN_USE)
				rows_in_use = value[ROWS_W-1:0];
		endfunction

		// returns 0 for a column word that the block drops
		function bit take_byte(logic kind, logic [7:0] value);
			int unsigned cols;
			int unsigned rows;
			logic [7:0]  mask;
			logic [7:0]  rose;
			logic [7:0]  fell;
			key_event_t  ev;
			key_event_t  found [$];
			if (kind == KIND_STATUS) begin
				column_pos = 0;
				if (value[SWITCH_BIT] != switch_level) begin
					switch_level = value[SWITCH_BIT];
					ev = '{key_index: '0, program_switch: 1'b1, pressed: switch_level,
						last_event: 1'b1};
					expected_events.push_back(ev);
				end
				return 1'b1;
			end
			cols = (columns_in_use > MAX_COLS) ? MAX_COLS : columns_in_use;
			rows = (rows_in_use > 8) ? 8 : rows_in_use;
			if (column_pos >= cols)
				return 1'b0;
			mask = 8'((1 << rows) - 1);
			rose = value & ~column_store[column_pos] & mask;
			fell = ~value & column_store[column_pos] & mask;
			column_store[column_pos] = value;
			for (int r = 0; r < 8; r++)
				if (rose[r]) begin
					ev = '{key_index: KEY_W'(column_pos * 8 + r), program_switch: 1'b0,
						pressed: 1'b1, last_event: 1'b0};
					found.push_back(ev);
				end
			for (int r = 0; r < 8; r++)
				if (fell[r]) begin
					ev = '{key_index: KEY_W'(column_pos * 8 + r), program_switch: 1'b0,
						pressed: 1'b0, last_event: 1'b0};
					found.push_back(ev);
				end
			if (found.size() > 0)
				found[found.size() - 1].last_event = 1'b1;
			foreach (found[i]) expected_events.push_back(found[i]);
			column_pos++;
			return 1'b1;
		endfunction

		function void report(string what);
			errors++;
			$display("%0t mismatch: %s", $realtime, what);
		endfunction

		function void match_event(logic [KEY_W-1:0] key, logic sw, logic pressed, logic last);
			key_event_t want;
			if (expected_events.size() == 0) begin
				report($sformatf("unexpected event key %0d switch %0b pressed %0b last %0b",
					key, sw, pressed, last));
				return;
			end
			want = expected_events.pop_front();
			if (key !== want.key_index)
				report($sformatf("key_index %0d, want %0d", key, want.key_index));
			if (sw !== want.program_switch)
				report($sformatf("program_switch %0b, want %0b (key %0d)", sw,
					want.program_switch, want.key_index));
			if (pressed !== want.pressed)
				report($sformatf("pressed %0b, want %0b (key %0d)", pressed, want.pressed,
					want.key_index));
			if (last !== want.last_event)
				report($sformatf("last_event %0b, want %0b (key %0d)", last, want.last_event,
					want.key_index));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [COL_BITS-1:0]    s_axis_tdata;   // byte_value
	logic                   s_axis_tuser;   // kind
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [COL_BITS-1:0]    m_axis_tdata;   // key_index[6:0], pressed[7]
	logic                   m_axis_tuser;   // program_switch
	logic                   m_axis_tlast;   // last_event
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bit send_idles;
	bit take_idles;

	keypad_event_predictor predictor = new();

	key_matrix_change_events #(.MAX_COLUMNS(MAX_COLS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= !(take_idles && $urandom_range(0, 99) < 33);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			predictor.match_event(m_axis_tdata[KEY_W-1:0], m_axis_tuser,
				m_axis_tdata[KEY_W], m_axis_tlast);
	end

	// entered and left just after a falling edge; tvalid stays high for the next word
	task automatic send_word(input logic kind, input logic [7:0] value, output bit used);
		while (send_idles && $urandom_range(0, 99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		used = predictor.take_byte(kind, value);
		@(negedge clk);
	endtask

	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (predictor.expected_events.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		predictor.write_reg(idx, value);
		@(negedge clk);
	endtask

	// whole reports with random content, some cut short or padded with surplus columns
	task automatic send_reports(input int target);
		int         sent;
		int         ncols;
		int unsigned cols_eff;
		bit         used;
		logic [7:0] value;
		logic [7:0] stored;
		sent = 0;
		while (sent < target) begin
			send_word(KIND_STATUS, 8'($urandom_range(0, 255)), used);
			sent++;
			cols_eff = (predictor.columns_in_use > MAX_COLS) ? MAX_COLS
				: predictor.columns_in_use;
			ncols = cols_eff;
			case ($urandom_range(0, 9))
				0: begin
					ncols += $urandom_range(1, 3);
				end
				1: begin
					ncols = $urandom_range(0, ncols);
				end
				default: ;
			endcase
			for (int i = 0; i < ncols; i++) begin
				stored = predictor.column_store[i % MAX_COLS];
				case ($urandom_range(0, 3))
					0: value = stored;
					1: value = stored ^ (8'd1 << $urandom_range(0, 7));
					default: value = 8'($urandom_range(0, 255));
				endcase
				send_word(KIND_COLUMN, value, used);
				if (used)
					sent++;
			end
		end
	endtask

	initial begin
		bit used;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_STATUS;
		cfg_we = 1'b0;
		cfg_index = REG_COLUMNS_IN_USE;
		cfg_data = '0;
		send_idles = 1'b1;
		take_idles = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// column word ahead of any status lands in column 0
		send_word(KIND_COLUMN, 8'hFF, used);
		send_word(KIND_STATUS, 8'h01, used);
		send_word(KIND_STATUS, 8'hFE, used);
		send_word(KIND_STATUS, 8'h00, used);
		send_word(KIND_STATUS, 8'h01, used);
		send_word(KIND_COLUMN, 8'h00, used);
		for (int i = 1; i < 15; i++)
			send_word(KIND_COLUMN, (i == 1) ? 8'hFF : 8'(8'h01 << (i % 8)) | 8'h80, used);
		send_word(KIND_COLUMN, 8'h80, used);
		send_word(KIND_COLUMN, 8'hFF, used);
		send_word(KIND_STATUS, 8'h00, used);
		send_word(KIND_COLUMN, 8'h3C, used);
		wait_quiet();

		// no idling on either side for a long stretch
		send_idles = 1'b0;
		take_idles = 1'b0;
		send_reports(100);
		wait_quiet();
		send_idles = 1'b1;
		take_idles = 1'b1;

		write_reg(REG_COLUMNS_IN_USE, 5'd1);
		write_reg(REG_ROWS_IN_USE, 5'd1);
		send_reports(40);
		wait_quiet();

		write_reg(REG_COLUMNS_IN_USE, 5'd0);
		send_reports(15);
		wait_quiet();

		write_reg(REG_COLUMNS_IN_USE, 5'd31);
		write_reg(REG_ROWS_IN_USE, 5'd15);
		send_reports(100);
		wait_quiet();

		write_reg(REG_COLUMNS_IN_USE, 5'd3);
		write_reg(REG_ROWS_IN_USE, 5'd0);
		send_reports(40);
		wait_quiet();

		write_reg(REG_COLUMNS_IN_USE, 5'd5);
		write_reg(REG_ROWS_IN_USE, 5'd4);
		send_reports(60);
		wait_quiet();

		write_reg(REG_COLUMNS_IN_USE, 5'd2);
		write_reg(REG_ROWS_IN_USE, 5'd8);
		send_reports(60);
		wait_quiet();

		write_reg(REG_COLUMNS_IN_USE, 5'd16);
		write_reg(REG_ROWS_IN_USE, 5'd7);
		send_reports(80);
		wait_quiet();

		if (predictor.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
